// ===== design/pth_pkg.sv =====
// Package for the pixel-to-hex-cell converter.
// Field widths, register indexes and reset values of the configuration registers.
// No dependencies.
package pth_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int RAW_FRAC      = 38;

    localparam int PIX_W      = 16;
    localparam int ORG_W      = 24;
    localparam int INV_W      = 16;
    localparam int COEF_W     = 16;
    localparam int HEX_W      = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 4;

    localparam int PIX_SHIFT = ORG_W - PIX_W;     // whole pixels to Q.8
    localparam int DIFF_W    = ORG_W + 1;         // pixel minus origin
    localparam int SCL_W     = DIFF_W + INV_W;    // scaled axis, Q.24
    localparam int PROD_W    = SCL_W + COEF_W;    // one matrix product, Q.38
    localparam int RAW_W     = PROD_W + 1;        // sum of two products

    localparam int NUM_STAGES = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_ORIGIN_X   = 4'd0,
        IDX_ORIGIN_Y   = 4'd1,
        IDX_INV_SIZE_X = 4'd2,
        IDX_INV_SIZE_Y = 4'd3,
        IDX_COEF_QX    = 4'd4,
        IDX_COEF_QY    = 4'd5,
        IDX_COEF_RX    = 4'd6,
        IDX_COEF_RY    = 4'd7
    } cfg_idx_t;

    localparam logic signed [ORG_W-1:0]  ORIGIN_X_RST   = 24'sd0;
    localparam logic signed [ORG_W-1:0]  ORIGIN_Y_RST   = 24'sd0;
    localparam logic        [INV_W-1:0]  INV_SIZE_X_RST = 16'd6553;
    localparam logic        [INV_W-1:0]  INV_SIZE_Y_RST = 16'd6553;
    localparam logic signed [COEF_W-1:0] COEF_QX_RST    = 16'sd9459;
    localparam logic signed [COEF_W-1:0] COEF_QY_RST    = -16'sd5461;
    localparam logic signed [COEF_W-1:0] COEF_RX_RST    = 16'sd0;
    localparam logic signed [COEF_W-1:0] COEF_RY_RST    = 16'sd10923;

endpackage

// ===== design/pixel_to_hex_cell.sv =====
// Pixel to hex cell converter: eight-stage pipeline from pixel to cube coordinates.
// Depends on pth_pkg (widths, register indexes, reset values).
//
// Accepts one pixel item per clock while in_stall is low and returns one (q, r, s)
// item per pixel, in order. Each item passes through the arithmetic chain: origin
// subtract, reciprocal multiply, orientation multiply, product sum and floor, s
// derivation, rounding with error, cube fix-up with clamp, and the final s clamp,
// one register stage each. A stall on the output only freezes stages that hold
// items; empty stages keep filling, so in_stall rises only when all eight stages
// are occupied. Configuration registers are written through cfg_wr_en / cfg_index /
// cfg_wdata and must only change while no item is in flight; indexes above seven
// are ignored. FRAC_BITS sets the fraction bits kept for rounding.
module pixel_to_hex_cell #(
    parameter int FRAC_BITS = pth_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_wr_en,
    input  logic [pth_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pth_pkg::CFG_DATA_W-1:0]         cfg_wdata,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pth_pkg::PIX_W-1:0]       pixel_x,
    input  logic signed [pth_pkg::PIX_W-1:0]       pixel_y,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pth_pkg::HEX_W-1:0]       hex_q,
    output logic signed [pth_pkg::HEX_W-1:0]       hex_r,
    output logic signed [pth_pkg::HEX_W-1:0]       hex_s
);

    localparam int NSTG   = pth_pkg::NUM_STAGES;
    localparam int SHIFT  = pth_pkg::RAW_FRAC - FRAC_BITS;
    localparam int FR_W   = pth_pkg::RAW_W - SHIFT;      // q, r after floor
    localparam int S_W    = FR_W + 1;                    // s = -q - r
    localparam int RND_W  = S_W - FRAC_BITS + 1;         // rounded integer
    localparam int RCMP_W = RND_W + 1;                   // recomputed coordinate
    localparam int HEX_W  = pth_pkg::HEX_W;

    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS:0]   UNIT = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [RCMP_W-1:0] HEX_MAX = RCMP_W'((2 ** (HEX_W - 1)) - 1);
    localparam logic signed [RCMP_W-1:0] HEX_MIN = RCMP_W'(-(2 ** (HEX_W - 1)));

    // ---------------- configuration registers ----------------
    logic signed [pth_pkg::ORG_W-1:0]  origin_x_reg, origin_y_reg;
    logic        [pth_pkg::INV_W-1:0]  inv_size_x_reg, inv_size_y_reg;
    logic signed [pth_pkg::COEF_W-1:0] coef_qx_reg, coef_qy_reg, coef_rx_reg, coef_ry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= pth_pkg::ORIGIN_X_RST;
            origin_y_reg   <= pth_pkg::ORIGIN_Y_RST;
            inv_size_x_reg <= pth_pkg::INV_SIZE_X_RST;
            inv_size_y_reg <= pth_pkg::INV_SIZE_Y_RST;
            coef_qx_reg    <= pth_pkg::COEF_QX_RST;
            coef_qy_reg    <= pth_pkg::COEF_QY_RST;
            coef_rx_reg    <= pth_pkg::COEF_RX_RST;
            coef_ry_reg    <= pth_pkg::COEF_RY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pth_pkg::IDX_ORIGIN_X:   origin_x_reg   <= cfg_wdata;
                pth_pkg::IDX_ORIGIN_Y:   origin_y_reg   <= cfg_wdata;
                pth_pkg::IDX_INV_SIZE_X: inv_size_x_reg <= cfg_wdata[pth_pkg::INV_W-1:0];
                pth_pkg::IDX_INV_SIZE_Y: inv_size_y_reg <= cfg_wdata[pth_pkg::INV_W-1:0];
                pth_pkg::IDX_COEF_QX:    coef_qx_reg    <= cfg_wdata[pth_pkg::COEF_W-1:0];
                pth_pkg::IDX_COEF_QY:    coef_qy_reg    <= cfg_wdata[pth_pkg::COEF_W-1:0];
                pth_pkg::IDX_COEF_RX:    coef_rx_reg    <= cfg_wdata[pth_pkg::COEF_W-1:0];
                pth_pkg::IDX_COEF_RY:    coef_ry_reg    <= cfg_wdata[pth_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- datapath helpers ----------------
    // round half away from zero at FRAC_BITS; returns {rounded, |error|}
    function automatic logic [RND_W+FRAC_BITS-1:0] round_err(input logic signed [S_W-1:0] v);
        logic [FRAC_BITS-1:0]     lo;
        logic                     up;
        logic [FRAC_BITS:0]       err_w;
        logic signed [RND_W-1:0]  rnd;
        lo    = v[FRAC_BITS-1:0];
        // negative ties round down (away from zero)
        up    = v[S_W-1] ? (lo > HALF) : (lo >= HALF);
        rnd   = RND_W'($signed(v[S_W-1:FRAC_BITS])) + RND_W'($signed({1'b0, up}));
        err_w = up ? (UNIT - {1'b0, lo}) : {1'b0, lo};
        return {rnd, err_w[FRAC_BITS-1:0]};
    endfunction

    function automatic logic signed [HEX_W-1:0] sat_hex(input logic signed [RCMP_W-1:0] v);
        logic signed [RCMP_W-1:0] c;
        if (v > HEX_MAX)
        begin
            c = HEX_MAX;
        end
        else if (v < HEX_MIN)
        begin
            c = HEX_MIN;
        end
        else
        begin
            c = v;
        end
        return c[HEX_W-1:0];
    endfunction

    // ---------------- stage 0: origin subtract ----------------
    logic signed [pth_pkg::DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;

    assign dx_next = {pixel_x[pth_pkg::PIX_W-1], pixel_x, {pth_pkg::PIX_SHIFT{1'b0}}}
                   - {origin_x_reg[pth_pkg::ORG_W-1], origin_x_reg};
    assign dy_next = {pixel_y[pth_pkg::PIX_W-1], pixel_y, {pth_pkg::PIX_SHIFT{1'b0}}}
                   - {origin_y_reg[pth_pkg::ORG_W-1], origin_y_reg};

    // ---------------- stage 1: reciprocal scale ----------------
    logic signed [pth_pkg::SCL_W-1:0] ux_reg, uy_reg, ux_next, uy_next;

    assign ux_next = pth_pkg::SCL_W'(dx_reg)
                   * pth_pkg::SCL_W'($signed({1'b0, inv_size_x_reg}));
    assign uy_next = pth_pkg::SCL_W'(dy_reg)
                   * pth_pkg::SCL_W'($signed({1'b0, inv_size_y_reg}));

    // ---------------- stage 2: orientation products ----------------
    logic signed [pth_pkg::PROD_W-1:0] pqx_reg, pqy_reg, prx_reg, pry_reg;
    logic signed [pth_pkg::PROD_W-1:0] pqx_next, pqy_next, prx_next, pry_next;

    assign pqx_next = pth_pkg::PROD_W'(coef_qx_reg) * pth_pkg::PROD_W'(ux_reg);
    assign pqy_next = pth_pkg::PROD_W'(coef_qy_reg) * pth_pkg::PROD_W'(uy_reg);
    assign prx_next = pth_pkg::PROD_W'(coef_rx_reg) * pth_pkg::PROD_W'(ux_reg);
    assign pry_next = pth_pkg::PROD_W'(coef_ry_reg) * pth_pkg::PROD_W'(uy_reg);

    // ---------------- stage 3: sum and floor to FRAC_BITS ----------------
    logic signed [pth_pkg::RAW_W-1:0] qraw, rraw;
    logic signed [FR_W-1:0]           qf_reg, rf_reg, qf_next, rf_next;

    assign qraw    = pth_pkg::RAW_W'(pqx_reg) + pth_pkg::RAW_W'(pqy_reg);
    assign rraw    = pth_pkg::RAW_W'(prx_reg) + pth_pkg::RAW_W'(pry_reg);
    assign qf_next = qraw[pth_pkg::RAW_W-1:SHIFT];
    assign rf_next = rraw[pth_pkg::RAW_W-1:SHIFT];

    // ---------------- stage 4: derive s ----------------
    logic signed [S_W-1:0] qe_reg, re_reg, se_reg, qe_next, re_next, se_next;

    assign qe_next = S_W'(qf_reg);
    assign re_next = S_W'(rf_reg);
    assign se_next = -qe_next - re_next;

    // ---------------- stage 5: round, rounding error ----------------
    logic signed [RND_W-1:0]   rq_reg, rr_reg, rs_reg, rq_next, rr_next, rs_next;
    logic [FRAC_BITS-1:0]      eq_reg, er_reg, es_reg, eq_next, er_next, es_next;

    assign {rq_next, eq_next} = round_err(qe_reg);
    assign {rr_next, er_next} = round_err(re_reg);
    assign {rs_next, es_next} = round_err(se_reg);

    // ---------------- stage 6: cube fix-up, clamp q and r ----------------
    logic signed [RCMP_W-1:0]  sel_q, sel_r;
    logic signed [HEX_W-1:0]   oq_reg, or_reg, oq_next, or_next;

    always_comb
    begin
        sel_q = RCMP_W'(rq_reg);
        sel_r = RCMP_W'(rr_reg);
        priority if (eq_reg > er_reg && eq_reg > es_reg)
        begin
            sel_q = -RCMP_W'(rr_reg) - RCMP_W'(rs_reg);
        end
        else if (er_reg > es_reg)
        begin
            sel_r = -RCMP_W'(rq_reg) - RCMP_W'(rs_reg);
        end
        else
        begin
            // s is rebuilt from the clamped q and r in the next stage
        end
    end

    assign oq_next = sat_hex(sel_q);
    assign or_next = sat_hex(sel_r);

    // ---------------- stage 7: s from clamped q, r ----------------
    logic signed [RCMP_W-1:0] sum_s;
    logic signed [HEX_W-1:0]  hq_reg, hr_reg, hs_reg;

    assign sum_s = -RCMP_W'(oq_reg) - RCMP_W'(or_reg);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (adv[1])
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end
        if (adv[2])
        begin
            pqx_reg <= pqx_next;
            pqy_reg <= pqy_next;
            prx_reg <= prx_next;
            pry_reg <= pry_next;
        end
        if (adv[3])
        begin
            qf_reg <= qf_next;
            rf_reg <= rf_next;
        end
        if (adv[4])
        begin
            qe_reg <= qe_next;
            re_reg <= re_next;
            se_reg <= se_next;
        end
        if (adv[5])
        begin
            rq_reg <= rq_next;
            rr_reg <= rr_next;
            rs_reg <= rs_next;
            eq_reg <= eq_next;
            er_reg <= er_next;
            es_reg <= es_next;
        end
        if (adv[6])
        begin
            oq_reg <= oq_next;
            or_reg <= or_next;
        end
        if (adv[7])
        begin
            hq_reg <= oq_reg;
            hr_reg <= or_reg;
            hs_reg <= sat_hex(sum_s);
        end
    end

    assign hex_q = hq_reg;
    assign hex_r = hr_reg;
    assign hex_s = hs_reg;

`ifndef SYNTHESIS
    // input back-pressure only when every stage holds an item
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("in_stall raised with an empty stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted item did not enter stage 0");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !adv[3]) |=> (vld_reg[3] && $stable(qf_reg) && $stable(rf_reg)))
        else $error("stalled item lost or changed in stage 3");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (eq_reg <= HALF && er_reg <= HALF && es_reg <= HALF))
        else $error("rounding error above one half");
`endif

endmodule

// ===== tb/pixel_to_hex_cell_tb.sv =====
// Self-checking testbench for pixel_to_hex_cell: predicts the hex cell of each pixel item
// in fixed point and compares q, r, s in order, under idle, stall and long hold-off phases.
// Depends on pth_pkg and the pixel_to_hex_cell RTL.
module pixel_to_hex_cell_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W      = pth_pkg::PIX_W;
    localparam int ORG_W      = pth_pkg::ORG_W;
    localparam int INV_W      = pth_pkg::INV_W;
    localparam int COEF_W     = pth_pkg::COEF_W;
    localparam int HEX_W      = pth_pkg::HEX_W;
    localparam int CFG_IDX_W  = pth_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pth_pkg::CFG_DATA_W;
    localparam int PIX_SHIFT  = pth_pkg::PIX_SHIFT;
    localparam int RAW_FRAC   = pth_pkg::RAW_FRAC;

    localparam int FRAC           = pth_pkg::FRAC_BITS_DEF;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = pth_pkg::NUM_STAGES + 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_REGS       = pth_pkg::IDX_COEF_RY + 1;

    localparam logic signed [PIX_W-1:0]  PIX_MAX  = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0]  PIX_MIN  = {1'b1, {(PIX_W-1){1'b0}}};
    localparam logic signed [ORG_W-1:0]  ORG_MAX  = {1'b0, {(ORG_W-1){1'b1}}};
    localparam logic signed [ORG_W-1:0]  ORG_MIN  = {1'b1, {(ORG_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << (COEF_W - 2));
    localparam logic        [INV_W-1:0]  INV_MAX  = '1;
    localparam logic        [INV_W-1:0]  INV_HALF = INV_W'(1 << (INV_W - 1));
    localparam logic signed [HEX_W-1:0]  HEX_MAX  = {1'b0, {(HEX_W-1){1'b1}}};
    localparam logic signed [HEX_W-1:0]  HEX_MIN  = {1'b1, {(HEX_W-1){1'b0}}};
    localparam logic signed [PIX_W-1:0]  PIX_CORNERS [4] = '{PIX_MAX, PIX_MIN, '0, '1};

    typedef struct packed {
        logic signed [ORG_W-1:0]  ox;
        logic signed [ORG_W-1:0]  oy;
        logic        [INV_W-1:0]  isx;
        logic        [INV_W-1:0]  isy;
        logic signed [COEF_W-1:0] cqx;
        logic signed [COEF_W-1:0] cqy;
        logic signed [COEF_W-1:0] crx;
        logic signed [COEF_W-1:0] cry;
    } layout_t;

    typedef struct packed {
        logic signed [HEX_W-1:0] q;
        logic signed [HEX_W-1:0] r;
        logic signed [HEX_W-1:0] s;
    } cell_t;

    localparam layout_t RESET_LAYOUT = '{pth_pkg::ORIGIN_X_RST, pth_pkg::ORIGIN_Y_RST,
        pth_pkg::INV_SIZE_X_RST, pth_pkg::INV_SIZE_Y_RST, pth_pkg::COEF_QX_RST,
        pth_pkg::COEF_QY_RST, pth_pkg::COEF_RX_RST, pth_pkg::COEF_RY_RST};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [PIX_W-1:0] pixel_x = '0;
    logic signed [PIX_W-1:0] pixel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [HEX_W-1:0] hex_q;
    logic signed [HEX_W-1:0] hex_r;
    logic signed [HEX_W-1:0] hex_s;

    layout_t lay = RESET_LAYOUT;
    cell_t   cells_due [$];
    int      errors = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_reqs = 0;
    int      hold_served = 0;
    int      quiet_cycles = 0;

    pixel_to_hex_cell #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hex_q     (hex_q),
        .hex_r     (hex_r),
        .hex_s     (hex_s)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic longint round_half_away(longint v);
        longint half;
        half = longint'(1) <<< (FRAC - 1);
        if (v >= 0)
            return (v + half) >>> FRAC;
        return -((-v + half) >>> FRAC);
    endfunction

    function automatic longint round_error(longint n, longint v);
        longint d;
        d = (n <<< FRAC) - v;
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic signed [HEX_W-1:0] clamp_hex(longint v);
        if (v > HEX_MAX)
            return HEX_MAX;
        if (v < HEX_MIN)
            return HEX_MIN;
        return v[HEX_W-1:0];
    endfunction

    function automatic cell_t hex_of_pixel(logic signed [PIX_W-1:0] px,
                                           logic signed [PIX_W-1:0] py);
        longint dx, dy, ux, uy, qraw, rraw, qf, rf, sf;
        longint rq, rr, rs, eq, er, es, oq, orr;
        cell_t  res;
        dx   = (longint'(px) <<< PIX_SHIFT) - longint'(lay.ox);
        dy   = (longint'(py) <<< PIX_SHIFT) - longint'(lay.oy);
        ux   = dx * longint'(lay.isx);
        uy   = dy * longint'(lay.isy);
        qraw = longint'(lay.cqx) * ux + longint'(lay.cqy) * uy;
        rraw = longint'(lay.crx) * ux + longint'(lay.cry) * uy;
        qf   = qraw >>> (RAW_FRAC - FRAC);
        rf   = rraw >>> (RAW_FRAC - FRAC);
        sf   = -qf - rf;
        rq   = round_half_away(qf);
        rr   = round_half_away(rf);
        rs   = round_half_away(sf);
        eq   = round_error(rq, qf);
        er   = round_error(rr, rf);
        es   = round_error(rs, sf);
        // ties: q only if strictly worst, then r only if strictly worse than s, else s
        if (eq > er && eq > es)
            rq = -rr - rs;
        else if (er > es)
            rr = -rq - rs;
        oq    = clamp_hex(rq);
        orr   = clamp_hex(rr);
        res.q = oq[HEX_W-1:0];
        res.r = orr[HEX_W-1:0];
        res.s = clamp_hex(-oq - orr);
        return res;
    endfunction

    // ---------------- checking ----------------

    task automatic check_field(string name, logic signed [HEX_W-1:0] exp_v,
                               logic signed [HEX_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cell_t due;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (cells_due.size() == 0)
                begin
                    errors++;
                    $error("result with no item pending: q=%0d r=%0d s=%0d",
                           hex_q, hex_r, hex_s);
                end
                else
                begin
                    due = cells_due.pop_front();
                    check_field("hex_q", due.q, hex_q);
                    check_field("hex_r", due.r, hex_r);
                    check_field("hex_s", due.s, hex_s);
                end
            end
            if (in_valid && !in_stall)
                cells_due.insert(cells_due.size(), hex_of_pixel(pixel_x, pixel_y));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("pixel_to_hex_cell_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_served)
            begin
                hold_served++;
                for (int n = 0; n < LONG_HOLD; n++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_pixel(logic signed [PIX_W-1:0] x, logic signed [PIX_W-1:0] y);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= x;
        pixel_y  <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        // an item accepted at this edge is queued by the next one
        @(posedge clk);
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_layout(layout_t l);
        logic [CFG_DATA_W-1:0] reg_data [NUM_REGS];
        wait_drained();
        lay = l;
        // 16-bit registers get junk above their width; only the low bits count
        reg_data[pth_pkg::IDX_ORIGIN_X]   = l.ox;
        reg_data[pth_pkg::IDX_ORIGIN_Y]   = l.oy;
        reg_data[pth_pkg::IDX_INV_SIZE_X] = {(CFG_DATA_W-INV_W)'($urandom), l.isx};
        reg_data[pth_pkg::IDX_INV_SIZE_Y] = {(CFG_DATA_W-INV_W)'($urandom), l.isy};
        reg_data[pth_pkg::IDX_COEF_QX]    = {(CFG_DATA_W-COEF_W)'($urandom), l.cqx};
        reg_data[pth_pkg::IDX_COEF_QY]    = {(CFG_DATA_W-COEF_W)'($urandom), l.cqy};
        reg_data[pth_pkg::IDX_COEF_RX]    = {(CFG_DATA_W-COEF_W)'($urandom), l.crx};
        reg_data[pth_pkg::IDX_COEF_RY]    = {(CFG_DATA_W-COEF_W)'($urandom), l.cry};
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= pth_pkg::cfg_idx_t'(i);
            cfg_wdata <= reg_data[i];
            @(posedge clk);
        end
        // unmapped index, must leave every register alone
        cfg_index <= CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NUM_REGS));
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic layout_t random_layout();
        layout_t l;
        int      cell_px;
        if ($urandom_range(9) < 6)
        begin
            cell_px = $urandom_range(64, 3);
            l.isx   = INV_W'((1 << INV_W) / cell_px);
            l.isy   = $urandom_range(1) ? l.isx
                                        : INV_W'((1 << INV_W) / $urandom_range(64, 3));
            l.ox    = ORG_W'(int'($urandom_range(2 * (1000 << PIX_SHIFT)))
                             - (1000 << PIX_SHIFT));
            l.oy    = ORG_W'(int'($urandom_range(2 * (1000 << PIX_SHIFT)))
                             - (1000 << PIX_SHIFT));
            if ($urandom_range(1))
            begin
                l.cqx = pth_pkg::COEF_QX_RST;
                l.cqy = pth_pkg::COEF_QY_RST;
                l.crx = pth_pkg::COEF_RX_RST;
                l.cry = pth_pkg::COEF_RY_RST;
            end
            else
            begin
                // flat-top orientation
                l.cqx = pth_pkg::COEF_RY_RST;
                l.cqy = pth_pkg::COEF_RX_RST;
                l.crx = pth_pkg::COEF_QY_RST;
                l.cry = pth_pkg::COEF_QX_RST;
            end
        end
        else
        begin
            l.ox  = ORG_W'($urandom);
            l.oy  = ORG_W'($urandom);
            l.isx = INV_W'($urandom);
            l.isy = INV_W'($urandom);
            l.cqx = COEF_W'($urandom);
            l.cqy = COEF_W'($urandom);
            l.crx = COEF_W'($urandom);
            l.cry = COEF_W'($urandom);
        end
        return l;
    endfunction

    task automatic send_random_pixels(int count);
        logic signed [PIX_W-1:0] x, y;
        int                      pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
            begin
                // around the origin, where cell boundaries are dense
                x = PIX_W'((lay.ox >>> PIX_SHIFT) + int'($urandom_range(600)) - 300);
                y = PIX_W'((lay.oy >>> PIX_SHIFT) + int'($urandom_range(600)) - 300);
            end
            else if (pick < 9)
            begin
                x = PIX_W'($urandom);
                y = PIX_W'($urandom);
            end
            else
            begin
                x = PIX_CORNERS[$urandom_range(3)];
                y = PIX_CORNERS[$urandom_range(3)];
            end
            send_pixel(x, y);
        end
    endtask

    task automatic run_random_phase(int send_idle, int recv_stall);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (int blk = 0; blk < 6; blk++)
        begin
            apply_layout(random_layout());
            send_random_pixels(50);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_layout();
        send_pixel('0, '0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MIN, PIX_MIN);
        send_pixel(PIX_MAX, PIX_MIN);
        send_pixel(PIX_MIN, PIX_MAX);
        send_pixel('1, PIX_W'(1));
    endtask

    task automatic test_saturation();
        layout_t l;
        l = '{ORG_MIN, ORG_MAX, INV_MAX, INV_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX};
        apply_layout(l);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MIN, PIX_MIN);
        send_pixel(PIX_MAX, PIX_MIN);
        send_pixel('0, '0);
        l = '{ORG_MAX, ORG_MIN, INV_MAX, INV_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN};
        apply_layout(l);
        send_pixel(PIX_MIN, PIX_MAX);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MIN, PIX_MIN);
    endtask

    task automatic test_zero_reciprocal();
        layout_t l;
        l     = random_layout();
        l.isx = '0;
        apply_layout(l);
        send_pixel(PIX_MAX, PIX_MIN);
        l.isy = '0;
        apply_layout(l);
        send_pixel(PIX_MIN, PIX_MAX);
    endtask

    // unit matrix at half scale: odd pixels land exactly on half-way points
    task automatic test_rounding_ties();
        layout_t l;
        l = '{'0, '0, INV_HALF, INV_HALF, COEF_ONE, '0, '0, COEF_ONE};
        apply_layout(l);
        send_pixel(PIX_W'(1), PIX_W'(1));
        send_pixel(PIX_W'(1), '1);
        send_pixel('1, '1);
        send_pixel(PIX_W'(3), PIX_W'(-5));
    endtask

    task automatic test_streaming();
        run_random_phase(0, 0);
    endtask

    task automatic test_sparse_input();
        run_random_phase(76, 0);
    endtask

    task automatic test_slow_output();
        run_random_phase(0, 76);
    endtask

    task automatic test_mixed_idling();
        run_random_phase(13, 13);
    endtask

    // long receiver hold while items keep coming: the pipeline must fill and push back
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        apply_layout(random_layout());
        hold_reqs++;
        send_random_pixels(80);
    endtask

    task automatic test_drain_pause();
        idle_pct  = 13;
        stall_pct = 13;
        send_random_pixels(30);
        wait_drained();
        send_random_pixels(30);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_saturation();
        test_zero_reciprocal();
        test_rounding_ties();
        test_streaming();
        test_sparse_input();
        test_slow_output();
        test_mixed_idling();
        test_backpressure();
        test_drain_pause();

        wait_drained();
        if (errors == 0 && cells_due.size() == 0)
            $display("pixel_to_hex_cell_tb: PASS");
        else
            $display("pixel_to_hex_cell_tb: FAIL");
        $finish;
    end

endmodule
